>>> rtl/core/jbr_pkg.sv
// Shared constants, types and codes for the bitstream reader with byte unstuffing.
package jbr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QF_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_00  = 8'h00;
    localparam logic [5:0] MAX_BITS = 6'd32;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_SKIP = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_READ = 2'd1,
        OP_SKIP = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_REFUSED    = 2'd1,
        STS_SKIP_UNFIN = 2'd2,
        STS_QFULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BS_IDLE   = 2'd0,
        BS_READ   = 2'd1,
        BS_SKIP   = 2'd2,
        BS_SETTLE = 2'd3
    } t_bstate;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       final_byte;
        logic [5:0] count;
        logic       unstuff;
    } t_cmd;

endpackage

>>> rtl/core/jbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/jbr_front.sv
// Front end: takes input beats, classifies them and holds them in a short command queue.
module jbr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    i_kind,
    input  logic [7:0]    i_data_byte,
    input  logic          i_final_byte,
    input  logic [5:0]    i_bit_count,
    input  logic          i_unstuff,
    output logic          o_cmd_valid,
    output jbr_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);

    jbr_pkg::t_cmd                 r_q [jbr_pkg::CQ_DEPTH];
    logic [jbr_pkg::CQ_AW-1:0]     r_wp, r_rp, n_wp, n_rp;
    logic [jbr_pkg::CQ_CW-1:0]     r_cnt, n_cnt;
    jbr_pkg::t_cmd                 cls;
    logic                          acc;

    // classify the beat
    always_comb begin
        unique case (i_kind)
            jbr_pkg::KIND_PUSH: cls.op = jbr_pkg::OP_PUSH;
            jbr_pkg::KIND_READ: cls.op = jbr_pkg::OP_READ;
            jbr_pkg::KIND_SKIP: cls.op = jbr_pkg::OP_SKIP;
            default:            cls.op = jbr_pkg::OP_NOP;
        endcase
        cls.data       = i_data_byte;
        cls.final_byte = i_final_byte;
        cls.count      = (i_bit_count > jbr_pkg::MAX_BITS) ? jbr_pkg::MAX_BITS : i_bit_count;
        cls.unstuff    = i_unstuff;
    end

    assign full        = (r_cnt == jbr_pkg::CQ_CW'(jbr_pkg::CQ_DEPTH));
    assign acc         = push && !full;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (acc) begin
            n_wp = (r_wp == jbr_pkg::CQ_AW'(jbr_pkg::CQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_cmd_take) begin
            n_rp = (r_rp == jbr_pkg::CQ_AW'(jbr_pkg::CQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (acc && !i_cmd_take) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!acc && i_cmd_take) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

>>> rtl/core/jbr_back.sv
// Back end: byte queue, bit reader sequencer and result register.
module jbr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  jbr_pkg::t_cmd i_cmd,
    output logic          o_cmd_take,
    output logic          empty,
    input  logic          pop,
    output logic [31:0]   o_value,
    output logic [5:0]    o_bits_delivered,
    output logic          o_at_end,
    output logic [1:0]    o_status
);

    localparam int QA_W = jbr_pkg::QA_W;
    localparam int QF_W = jbr_pkg::QF_W;

    jbr_pkg::t_bstate r_state, n_state;

    // architectural state
    logic [QA_W-1:0] r_head, n_head;
    logic [QF_W-1:0] r_fill, n_fill;
    logic [7:0]      r_cur, n_cur;
    logic [3:0]      r_pos, n_pos;
    logic            r_ff, n_ff, r_last, n_last, r_end, n_end, r_rep, n_rep;

    // snapshot for refused reads
    logic [QA_W-1:0] r_s_head, n_s_head;
    logic [QF_W-1:0] r_s_fill, n_s_fill;
    logic [7:0]      r_s_cur, n_s_cur;
    logic [3:0]      r_s_pos, n_s_pos;
    logic            r_s_ff, n_s_ff, r_s_rep, n_s_rep;

    // per-command working registers
    logic [5:0]  r_rem, n_rem, r_got, n_got;
    logic [31:0] r_acc, n_acc;
    logic        r_again, n_again, r_unstuff, n_unstuff;
    logic [7:0]  r_target, n_target;

    // result register
    logic             r_ovalid, n_ovalid;
    logic [31:0]      r_o_value, n_o_value;
    logic [5:0]       r_o_bits, n_o_bits;
    logic             r_o_end, n_o_end;
    jbr_pkg::t_status r_o_status, n_o_status;

    logic            out_free, start, q_full, push_write;
    logic [QA_W:0]   wsum;
    logic [QA_W-1:0] waddr, head_inc;
    logic [7:0]      rdata;

    logic       f_ok, f_stuffed, f_drop, fetch_now, read_fin, skip_fin, match;
    logic [7:0] f_byte;

    logic [7:0]  tk_byte, tk_bits;
    logic [3:0]  tk_pos, tk_avail, tk_k, tk_pos_n;
    logic [5:0]  tk_rem, tk_got;
    logic [31:0] tk_acc;

    jbr_ram #(
        .WIDTH (8),
        .DEPTH (jbr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (start && (i_cmd.op == jbr_pkg::OP_PUSH) && push_write),
        .i_waddr (waddr),
        .i_wdata (i_cmd.data),
        .i_raddr (n_head),
        .o_rdata (rdata)
    );

    assign out_free   = !r_ovalid || pop;
    assign start      = (r_state == jbr_pkg::BS_IDLE) && i_cmd_valid && out_free;
    assign o_cmd_take = start;

    assign q_full     = (r_fill == QF_W'(jbr_pkg::QUEUE_DEPTH));
    assign push_write = !r_last && !q_full;
    assign wsum       = {1'b0, r_head} + (QA_W+1)'(r_fill);
    assign waddr      = (wsum >= (QA_W+1)'(jbr_pkg::QUEUE_DEPTH))
                        ? QA_W'(wsum - (QA_W+1)'(jbr_pkg::QUEUE_DEPTH)) : wsum[QA_W-1:0];
    assign head_inc   = (r_head == QA_W'(jbr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // byte source: replayed byte first, then the queue head
    assign f_ok      = r_rep || (r_fill != '0);
    assign f_byte    = r_rep ? r_cur : rdata;
    assign f_stuffed = r_ff && (f_byte == jbr_pkg::BYTE_00) && !r_again;
    assign f_drop    = f_ok && f_stuffed && r_unstuff;
    assign fetch_now = r_again || r_pos[3];
    assign match     = (f_byte == r_target);

    // bit take from one byte
    assign tk_byte  = fetch_now ? f_byte : r_cur;
    assign tk_pos   = fetch_now ? 4'd0 : r_pos;
    assign tk_avail = 4'd8 - tk_pos;
    assign tk_k     = (r_rem < {2'b00, tk_avail}) ? r_rem[3:0] : tk_avail;
    assign tk_bits  = (tk_byte & (8'hFF >> tk_pos)) >> (tk_avail - tk_k);
    assign tk_acc   = (r_acc << tk_k) | {24'd0, tk_bits};
    assign tk_rem   = r_rem - {2'b00, tk_k};
    assign tk_got   = r_got + {2'b00, tk_k};
    assign tk_pos_n = tk_pos + tk_k;

    assign read_fin = fetch_now ? (!f_ok || (!f_drop && (tk_rem == '0))) : (tk_rem == '0);
    assign skip_fin = !f_ok || match;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jbr_pkg::BS_IDLE: begin
                if (start) begin
                    unique case (i_cmd.op)
                        jbr_pkg::OP_PUSH: n_state = push_write ? jbr_pkg::BS_SETTLE
                                                               : jbr_pkg::BS_IDLE;
                        jbr_pkg::OP_READ: n_state = (r_end || (i_cmd.count == '0))
                                                    ? jbr_pkg::BS_IDLE : jbr_pkg::BS_READ;
                        jbr_pkg::OP_SKIP: n_state = r_end ? jbr_pkg::BS_IDLE
                                                          : jbr_pkg::BS_SKIP;
                        default:          n_state = jbr_pkg::BS_IDLE;
                    endcase
                end
            end
            jbr_pkg::BS_READ:   n_state = read_fin ? jbr_pkg::BS_IDLE : jbr_pkg::BS_READ;
            jbr_pkg::BS_SKIP:   n_state = skip_fin ? jbr_pkg::BS_IDLE : jbr_pkg::BS_SKIP;
            jbr_pkg::BS_SETTLE: n_state = jbr_pkg::BS_IDLE;
            default:            n_state = jbr_pkg::BS_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_head = r_head;  n_fill = r_fill;  n_cur = r_cur;  n_pos = r_pos;
        n_ff = r_ff;  n_last = r_last;  n_end = r_end;  n_rep = r_rep;
        n_s_head = r_s_head;  n_s_fill = r_s_fill;  n_s_cur = r_s_cur;
        n_s_pos = r_s_pos;  n_s_ff = r_s_ff;  n_s_rep = r_s_rep;
        n_rem = r_rem;  n_got = r_got;  n_acc = r_acc;
        n_again = r_again;  n_unstuff = r_unstuff;  n_target = r_target;
        n_ovalid = r_ovalid && !pop;
        n_o_value = r_o_value;  n_o_bits = r_o_bits;
        n_o_end = r_o_end;  n_o_status = r_o_status;

        unique case (r_state)
            jbr_pkg::BS_IDLE: begin
                if (start) begin
                    n_o_value  = '0;
                    n_o_bits   = '0;
                    n_o_end    = r_end;
                    n_o_status = jbr_pkg::STS_OK;
                    case (i_cmd.op)
                        jbr_pkg::OP_PUSH: begin
                            n_ovalid = 1'b1;
                            if (!r_last && q_full) begin
                                n_o_status = jbr_pkg::STS_QFULL;
                            end else if (push_write) begin
                                n_fill = r_fill + 1'b1;
                                n_last = i_cmd.final_byte;
                            end
                        end
                        jbr_pkg::OP_READ: begin
                            if (r_end || (i_cmd.count == '0)) begin
                                n_ovalid = 1'b1;
                            end else begin
                                n_s_head  = r_head;
                                n_s_fill  = r_fill;
                                n_s_cur   = r_cur;
                                n_s_pos   = r_pos;
                                n_s_ff    = r_ff;
                                n_s_rep   = r_rep;
                                n_rem     = i_cmd.count;
                                n_got     = '0;
                                n_acc     = '0;
                                n_again   = 1'b0;
                                n_unstuff = i_cmd.unstuff;
                            end
                        end
                        jbr_pkg::OP_SKIP: begin
                            if (r_end) begin
                                n_ovalid = 1'b1;
                            end else begin
                                n_pos    = 4'd8;
                                n_target = i_cmd.data;
                            end
                        end
                        default: n_ovalid = 1'b1;
                    endcase
                end
            end
            jbr_pkg::BS_READ: begin
                if (fetch_now && !f_ok) begin
                    n_ovalid   = 1'b1;
                    n_o_bits   = '0;
                    n_o_status = jbr_pkg::STS_OK;
                    n_again    = 1'b0;
                    if (r_last) begin
                        // stream end: missing bits read as zero
                        n_end     = 1'b1;
                        n_o_end   = 1'b1;
                        n_o_value = r_acc << r_rem;
                        n_o_bits  = r_got;
                    end else begin
                        // starved: roll back to the state at command start
                        n_head     = r_s_head;
                        n_fill     = r_s_fill;
                        n_cur      = r_s_cur;
                        n_pos      = r_s_pos;
                        n_ff       = r_s_ff;
                        n_rep      = r_s_rep;
                        n_o_end    = r_end;
                        n_o_value  = '0;
                        n_o_status = jbr_pkg::STS_REFUSED;
                    end
                end else begin
                    if (fetch_now) begin
                        if (r_rep) begin
                            n_rep = 1'b0;
                        end else begin
                            n_head = head_inc;
                            n_fill = r_fill - 1'b1;
                        end
                        n_cur = f_byte;
                        n_ff  = (f_byte == jbr_pkg::BYTE_FF);
                    end
                    if (fetch_now && f_drop) begin
                        n_again = 1'b1;
                        n_pos   = 4'd0;
                    end else begin
                        n_again = 1'b0;
                        n_acc   = tk_acc;
                        n_rem   = tk_rem;
                        n_got   = tk_got;
                        n_pos   = tk_pos_n;
                        if (tk_rem == '0) begin
                            n_ovalid   = 1'b1;
                            n_o_value  = tk_acc;
                            n_o_bits   = tk_got;
                            n_o_end    = r_end;
                            n_o_status = jbr_pkg::STS_OK;
                        end
                    end
                end
            end
            jbr_pkg::BS_SKIP: begin
                if (!f_ok) begin
                    n_ovalid   = 1'b1;
                    n_o_value  = '0;
                    n_o_bits   = '0;
                    n_end      = r_end || r_last;
                    n_o_end    = r_end || r_last;
                    n_o_status = r_last ? jbr_pkg::STS_OK : jbr_pkg::STS_SKIP_UNFIN;
                end else begin
                    if (r_rep) begin
                        n_rep = 1'b0;
                    end else begin
                        n_head = head_inc;
                        n_fill = r_fill - 1'b1;
                    end
                    n_cur = f_byte;
                    n_ff  = (f_byte == jbr_pkg::BYTE_FF);
                    n_pos = 4'd8;
                    if (match) begin
                        n_rep      = 1'b1;
                        n_ovalid   = 1'b1;
                        n_o_value  = '0;
                        n_o_bits   = '0;
                        n_o_end    = r_end;
                        n_o_status = jbr_pkg::STS_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= jbr_pkg::BS_IDLE;
            r_head   <= '0;
            r_fill   <= '0;
            r_cur    <= '0;
            r_pos    <= 4'd8;
            r_ff     <= 1'b0;
            r_last   <= 1'b0;
            r_end    <= 1'b0;
            r_rep    <= 1'b0;
            r_again  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_cur    <= n_cur;
            r_pos    <= n_pos;
            r_ff     <= n_ff;
            r_last   <= n_last;
            r_end    <= n_end;
            r_rep    <= n_rep;
            r_again  <= n_again;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_head   <= n_s_head;
        r_s_fill   <= n_s_fill;
        r_s_cur    <= n_s_cur;
        r_s_pos    <= n_s_pos;
        r_s_ff     <= n_s_ff;
        r_s_rep    <= n_s_rep;
        r_rem      <= n_rem;
        r_got      <= n_got;
        r_acc      <= n_acc;
        r_unstuff  <= n_unstuff;
        r_target   <= n_target;
        r_o_value  <= n_o_value;
        r_o_bits   <= n_o_bits;
        r_o_end    <= n_o_end;
        r_o_status <= n_o_status;
    end

    assign empty            = !r_ovalid;
    assign o_value          = r_o_value;
    assign o_bits_delivered = r_o_bits;
    assign o_at_end         = r_o_end;
    assign o_status         = r_o_status;

endmodule

>>> rtl/core/jpeg_bit_reader_unstuff.sv
// Top level of the bitstream reader with JPEG byte unstuffing.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  request  | push / full            | i_kind, i_data_byte, i_final_byte,
//           |                        | i_bit_count, i_unstuff
//  result   | empty / pop            | o_value, o_bits_delivered, o_at_end, o_status
//
// A request beat lands in a two-entry command queue, so the front keeps taking beats
// while the back is busy, until it is full. The back runs one command at a time: a push
// that is stored passes a settle state for the queue RAM read; a read fetches bytes one
// at a time, a stuffed 00 dropped in a step of its own, until done or a byte is missing;
// a skip compares bytes in turn until one matches or they run out. Reset is synchronous,
// active low; a result holds in the output register and stalls the back until popped.
module jpeg_bit_reader_unstuff (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    input  logic [5:0]  i_bit_count,
    input  logic        i_unstuff,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_value,
    output logic [5:0]  o_bits_delivered,
    output logic        o_at_end,
    output logic [1:0]  o_status
);

    // front to back command path
    logic          cmd_valid;
    jbr_pkg::t_cmd cmd;
    logic          cmd_take;

    // front: classification, clamping of the bit count, command queue
    jbr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_bit_count  (i_bit_count),
        .i_unstuff    (i_unstuff),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_take   (cmd_take)
    );

    // back: byte queue, bit sequencer with roll-back, result register
    jbr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd_valid),
        .i_cmd            (cmd),
        .o_cmd_take       (cmd_take),
        .empty            (empty),
        .pop              (pop),
        .o_value          (o_value),
        .o_bits_delivered (o_bits_delivered),
        .o_at_end         (o_at_end),
        .o_status         (o_status)
    );

endmodule
